// ===== hdl/alt_pkg.sv =====
// shared types and constants for the allocation leak tracker
`default_nettype none
package alt_pkg;
  localparam int TableEntries = 32;
  localparam int SlotBits = $clog2(TableEntries);
  localparam int CountBits = $clog2(TableEntries + 1);
  localparam int AccessCountBits = 16;
  localparam logic [31:0] LeakAgeReset = 32'd300;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_ACCESS = 2'd1,
    OP_FREE   = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_ACCESSED = 3'd3,
    ST_FREED    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_LEAK     = 3'd6,
    ST_DONE     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
    logic [31:0] size;
    logic [21:0] owner_id;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_addr;
    logic [31:0] entry_size;
    logic [21:0] entry_owner;
    logic [5:0]  tracked_count;
    logic [5:0]  leaked_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0]                base;
    logic [31:0]                size;
    logic [21:0]                owner;
    logic [31:0]                birth;
    logic [AccessCountBits-1:0] acc;
    logic                       leaked;
  } slot_t;
endpackage
`default_nettype wire

// ===== hdl/allocation_leak_tracker_top.sv =====
// allocation leak tracker top level: sequencer, valid bits and output register
// alloc, access, free: slots read (S_READ) and tested (S_EVAL) in turn, stop at first hit; result
// loaded through S_WRITE and S_EMIT for a hit or after a full scan
// check: a leak report per old idle slot, then the done result, each can be held by out_ready stalls
// one item in flight; in_ready returns the cycle after the last result is loaded
// synchronous reset clears valid bits and counts, sets leak age to 300, no memory sweep
`default_nettype none
module allocation_leak_tracker_top
  import alt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    in_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  output out_item_t        out_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);
  state_t state, state_next;
  in_item_t item;
  logic [31:0] leak_age;
  logic [TableEntries-1:0] valid_bits;
  logic [SlotBits-1:0] idx;
  logic [CountBits-1:0] live, leaked;
  logic table_full;
  logic found;
  logic [SlotBits-1:0] found_idx;
  logic free_found;
  logic [SlotBits-1:0] free_idx;
  slot_t rd_slot, found_slot;
  logic hit, old_idle;
  logic ram_we;
  logic [SlotBits-1:0] ram_waddr;
  slot_t ram_wdata;
  logic slot_live;
  logic scan_end;
  logic emit_final;
  out_item_t out_next;
  logic show_slot, show_item;

  alt_slot_ram u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(idx), .rd_data(rd_slot)
  );

  alt_slot_eval u_eval (
    .slot(rd_slot), .addr(item.addr), .now_seconds(item.now_seconds),
    .leak_age(leak_age), .hit(hit), .old_idle(old_idle)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign slot_live = valid_bits[idx];
  assign scan_end  = (idx == SlotBits'(TableEntries - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_EVAL;
      S_EVAL: begin
        if (item.op == OP_CHECK) begin
          if (slot_live && old_idle) state_next = S_WRITE;
          else if (scan_end) state_next = S_EMIT;
          else state_next = S_READ;
        end else if ((slot_live && hit) || scan_end) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_WRITE: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          // a report from the last slot is followed by the done result
          if (item.op == OP_CHECK && !emit_final) state_next = scan_end ? S_EMIT : S_READ;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory write outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = found_idx;
    ram_wdata = found_slot;
    if (state == S_WRITE) begin
      unique case (item.op)
        OP_ALLOC: begin
          ram_we    = !found && free_found && (live < CountBits'(TableEntries));
          ram_waddr = free_idx;
          ram_wdata = '{base: item.addr, size: item.size, owner: item.owner_id,
                        birth: item.now_seconds, acc: '0, leaked: 1'b0};
        end
        OP_ACCESS: begin
          ram_we = found && (found_slot.acc != '1);
          ram_wdata.acc = found_slot.acc + 1'b1;
        end
        OP_CHECK: begin
          ram_we = 1'b1;
          ram_wdata.leaked = 1'b1;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      leak_age   <= LeakAgeReset;
      valid_bits <= '0;
      live       <= '0;
      leaked     <= '0;
      out_valid  <= 1'b0;
      emit_final <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) leak_age <= cfg_data;
      if (state == S_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            idx        <= '0;
            table_full <= (live >= CountBits'(TableEntries));
            found      <= 1'b0;
            free_found <= 1'b0;
            emit_final <= 1'b0;
          end
        end
        S_READ: ;
        S_EVAL: begin
          if (item.op == OP_CHECK) begin
            if (slot_live && old_idle) begin
              found_idx  <= idx;
              found_slot <= rd_slot;
            end else if (scan_end) begin
              emit_final <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            if (!slot_live && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            if (slot_live && hit) begin
              found      <= 1'b1;
              found_idx  <= idx;
              found_slot <= rd_slot;
            end else if (!scan_end) begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_WRITE: begin
          emit_final <= (item.op != OP_CHECK);
          unique case (item.op)
            OP_ALLOC: if (ram_we) begin
              valid_bits[free_idx] <= 1'b1;
              live <= live + 1'b1;
            end
            OP_FREE: if (found) begin
              valid_bits[found_idx] <= 1'b0;
              if (found_slot.leaked && leaked != '0) leaked <= leaked - 1'b1;
              if (live != '0) live <= live - 1'b1;
            end
            OP_CHECK: leaked <= leaked + 1'b1;
            default: ;
          endcase
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (item.op == OP_CHECK && !emit_final) begin
              if (scan_end) emit_final <= 1'b1;
              else idx <= idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result fields for the current transaction
  always_comb begin
    out_next = '0;
    show_slot = 1'b0;
    show_item = 1'b0;
    out_next.tracked_count = 6'(live);
    out_next.leaked_count  = 6'(leaked);
    out_next.last          = 1'b1;
    case (item.op)
      OP_ALLOC: begin
        if (table_full || (!found && !free_found)) begin
          out_next.status = ST_FULL;
        end else if (found) begin
          out_next.status = ST_OVERLAP;
          show_slot = 1'b1;
        end else begin
          out_next.status = ST_RECORDED;
          show_item = 1'b1;
        end
      end
      OP_ACCESS: begin
        out_next.status = found ? ST_ACCESSED : ST_NOTFOUND;
        show_slot = found;
      end
      OP_FREE: begin
        out_next.status = found ? ST_FREED : ST_NOTFOUND;
        show_slot = found;
      end
      OP_CHECK: begin
        out_next.status = emit_final ? ST_DONE : ST_LEAK;
        out_next.last   = emit_final;
        show_slot = !emit_final;
      end
      default: out_next.status = ST_DONE;
    endcase
    if (show_item) begin
      out_next.entry_addr  = item.addr;
      out_next.entry_size  = item.size;
      out_next.entry_owner = item.owner_id;
    end else if (show_slot) begin
      out_next.entry_addr  = found_slot.base;
      out_next.entry_size  = found_slot.size;
      out_next.entry_owner = found_slot.owner;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    leaked <= live) else $error("leaked count above live count");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CountBits'(TableEntries)) else $error("live count overflow");
`endif
endmodule
`default_nettype wire

// ===== hdl/alt_slot_ram.sv =====
// slot table memory, one write port and one registered read port
`default_nettype none
module alt_slot_ram
  import alt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [SlotBits-1:0] wr_addr,
  input  wire slot_t               wr_data,
  input  wire logic [SlotBits-1:0] rd_addr,
  output slot_t                    rd_data
);
  slot_t mem [TableEntries];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/alt_slot_eval.sv =====
// shared per-slot compare unit: range hit and leak age test
`default_nettype none
module alt_slot_eval
  import alt_pkg::*;
(
  input  wire slot_t        slot,
  input  wire logic [63:0]  addr,
  input  wire logic [31:0]  now_seconds,
  input  wire logic [31:0]  leak_age,
  output logic              hit,
  output logic              old_idle
);
  logic [63:0] diff;
  logic [31:0] age;

  // range test, base <= a and a - base < size
  always_comb begin
    diff = addr - slot.base;
    hit  = (addr >= slot.base) && (diff < {32'd0, slot.size});
  end

  // leak candidate, unmarked, never accessed and too old
  always_comb begin
    age = now_seconds - slot.birth;
    old_idle = !slot.leaked && (slot.acc == '0) && (now_seconds >= slot.birth)
               && (age > leak_age);
  end
endmodule
`default_nettype wire
